// ----- sv/hrt_pkg.sv -----
// ----------------------------------------------------------------------------
// hrt_pkg
// Shared types and constants for the HTTP request header tokenizer: field
// widths, parse phases, byte roles, method, version and status codes.
// ----------------------------------------------------------------------------
package hrt_pkg;

    // Field widths
    localparam int BYTE_W    = 8;
    localparam int ROLE_W    = 3;
    localparam int METHOD_W  = 4;
    localparam int VERSION_W = 2;
    localparam int STATUS_W  = 2;
    localparam int SKIP_W    = 3;
    localparam int BLM_W     = 2;

    // Parse phases, one-hot
    typedef enum logic [11:0] {
        PH_METHOD    = 12'b0000_0000_0001,
        PH_PSECOND   = 12'b0000_0000_0010,
        PH_MSKIP     = 12'b0000_0000_0100,
        PH_URL       = 12'b0000_0000_1000,
        PH_PROTOSKIP = 12'b0000_0001_0000,
        PH_VERSION   = 12'b0000_0010_0000,
        PH_EOLSKIP   = 12'b0000_0100_0000,
        PH_NAME      = 12'b0000_1000_0000,
        PH_VALUE     = 12'b0001_0000_0000,
        PH_VALUELF   = 12'b0010_0000_0000,
        PH_BODY      = 12'b0100_0000_0000,
        PH_DONE      = 12'b1000_0000_0000
    } hrt_phase_t;

    // Byte roles
    localparam logic [ROLE_W-1:0] ROLE_SKIP  = 3'd0;
    localparam logic [ROLE_W-1:0] ROLE_URL   = 3'd1;
    localparam logic [ROLE_W-1:0] ROLE_NAME  = 3'd2;
    localparam logic [ROLE_W-1:0] ROLE_VALUE = 3'd3;
    localparam logic [ROLE_W-1:0] ROLE_BODY  = 3'd4;

    // Method codes
    localparam logic [METHOD_W-1:0] M_UNKNOWN = 4'd0;
    localparam logic [METHOD_W-1:0] M_GET     = 4'd1;
    localparam logic [METHOD_W-1:0] M_OPTIONS = 4'd2;
    localparam logic [METHOD_W-1:0] M_POST    = 4'd3;
    localparam logic [METHOD_W-1:0] M_PUT     = 4'd4;
    localparam logic [METHOD_W-1:0] M_PATCH   = 4'd5;
    localparam logic [METHOD_W-1:0] M_HEAD    = 4'd6;
    localparam logic [METHOD_W-1:0] M_DELETE  = 4'd7;
    localparam logic [METHOD_W-1:0] M_CONNECT = 4'd8;
    localparam logic [METHOD_W-1:0] M_TRACE   = 4'd9;

    // Version codes
    localparam logic [VERSION_W-1:0] V_UNKNOWN = 2'd0;
    localparam logic [VERSION_W-1:0] V_HTTP10  = 2'd1;
    localparam logic [VERSION_W-1:0] V_HTTP11  = 2'd2;

    // Parse status codes
    localparam logic [STATUS_W-1:0] ST_PARSING   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_COMPLETE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NEED_MORE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_PIPELINED = 2'd3;

    // Blank line tracker
    localparam logic [BLM_W-1:0] BLM_IDLE       = 2'd0;
    localparam logic [BLM_W-1:0] BLM_LINE_START = 2'd1;
    localparam logic [BLM_W-1:0] BLM_SAW_CR     = 2'd2;

    // Characters
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_COLON   = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF      = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_ONE     = 8'h31;
    localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [BYTE_W-1:0] CH_C       = 8'h43;
    localparam logic [BYTE_W-1:0] CH_D       = 8'h44;
    localparam logic [BYTE_W-1:0] CH_G       = 8'h47;
    localparam logic [BYTE_W-1:0] CH_H       = 8'h48;
    localparam logic [BYTE_W-1:0] CH_O       = 8'h4F;
    localparam logic [BYTE_W-1:0] CH_P       = 8'h50;
    localparam logic [BYTE_W-1:0] CH_T       = 8'h54;
    localparam logic [BYTE_W-1:0] CH_U       = 8'h55;
    localparam logic [BYTE_W-1:0] CASE_BIT   = 8'h20;

    // Remaining bytes of each method word, its space included
    localparam logic [SKIP_W-1:0] SKIP_GET     = 3'd3;
    localparam logic [SKIP_W-1:0] SKIP_OPTIONS = 3'd7;
    localparam logic [SKIP_W-1:0] SKIP_HEAD    = 3'd4;
    localparam logic [SKIP_W-1:0] SKIP_DELETE  = 3'd6;
    localparam logic [SKIP_W-1:0] SKIP_CONNECT = 3'd7;
    localparam logic [SKIP_W-1:0] SKIP_TRACE   = 3'd5;
    localparam logic [SKIP_W-1:0] SKIP_POST    = 3'd3;
    localparam logic [SKIP_W-1:0] SKIP_PUT     = 3'd2;
    localparam logic [SKIP_W-1:0] SKIP_PATCH   = 3'd4;
    // "HTTP/1." and the CR LF after the version digit
    localparam logic [SKIP_W-1:0] SKIP_PROTO   = 3'd7;
    localparam logic [SKIP_W-1:0] SKIP_EOL     = 3'd2;

    // One tagged result
    typedef struct packed {
        logic [BYTE_W-1:0]    out_byte;
        logic [ROLE_W-1:0]    byte_role;
        logic                 token_end;
        logic [METHOD_W-1:0]  method_code;
        logic [VERSION_W-1:0] version_code;
        logic [STATUS_W-1:0]  parse_status;
    } hrt_result_t;

endpackage

// ----- sv/hrt_in_if.sv -----
// ----------------------------------------------------------------------------
// hrt_in_if
// Request byte channel: valid/ready handshake carrying one byte with its
// buffer end and request start flags.
// ----------------------------------------------------------------------------
interface hrt_in_if
    import hrt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              buffer_end;
    logic              start_request;

    modport source (output valid, output data_byte, output buffer_end,
                    output start_request, input ready);
    modport sink   (input valid, input data_byte, input buffer_end,
                    input start_request, output ready);
endinterface

// ----- sv/hrt_out_if.sv -----
// ----------------------------------------------------------------------------
// hrt_out_if
// Tagged byte channel: valid/ready handshake carrying one byte with its
// role, token end flag, held method and version, and parse status.
// ----------------------------------------------------------------------------
interface hrt_out_if
    import hrt_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [BYTE_W-1:0]    out_byte;
    logic [ROLE_W-1:0]    byte_role;
    logic                 token_end;
    logic [METHOD_W-1:0]  method_code;
    logic [VERSION_W-1:0] version_code;
    logic [STATUS_W-1:0]  parse_status;

    modport source (output valid, output out_byte, output byte_role,
                    output token_end, output method_code, output version_code,
                    output parse_status, input ready);
    modport sink   (input valid, input out_byte, input byte_role,
                    input token_end, input method_code, input version_code,
                    input parse_status, output ready);
endinterface

// ----- sv/http_request_header_tokenizer_top.sv -----
// ----------------------------------------------------------------------------
// http_request_header_tokenizer_top
// Byte-wide HTTP/1.1 request tokenizer: decodes method and version, tags
// every byte as url, header name, header value, body or skipped.
//
//   Channel  Dir  Payload                                        Handshake
//   rx       in   data_byte, buffer_end, start_request           valid/ready
//   tx       out  out_byte, byte_role, token_end, method_code,   valid/ready
//                 version_code, parse_status
//
// One byte per cycle sustained while tx does not stall; an rx transfer
// passes the input register, then parse logic into the result register.
// The per-byte phase machine sets the rate: its update is combinational.
// Reset returns the parser to the method phase; nothing to clear afterward.
// A stall on tx holds both stages; rx is still taken while its stage is free.
// ----------------------------------------------------------------------------
module http_request_header_tokenizer_top
    import hrt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    hrt_in_if.sink    rx,
    hrt_out_if.source tx
);

    // Input stage
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_end_reg;
    logic              in_start_reg;

    // Result stage
    logic        out_valid_reg;
    hrt_result_t res_reg;
    hrt_result_t res_next;

    // Parser state
    hrt_phase_t           phase_reg,   phase_next;
    logic [SKIP_W-1:0]    skip_reg,    skip_next;
    logic [METHOD_W-1:0]  method_reg,  method_next;
    logic [VERSION_W-1:0] version_reg, version_next;
    logic [BLM_W-1:0]     blm_reg,     blm_next;
    logic                 vsp_reg,     vsp_next;

    logic advance;
    logic step;

    // Move the input stage forward when the result register is free
    assign advance  = !out_valid_reg || tx.ready;
    assign step     = in_valid_reg && advance;
    assign rx.ready = !in_valid_reg || advance;

    // Per-byte parse
    always_comb
    begin
        hrt_phase_t           cur_phase;
        logic [SKIP_W-1:0]    cur_skip;
        logic [METHOD_W-1:0]  cur_method;
        logic [VERSION_W-1:0] cur_version;
        logic [BLM_W-1:0]     cur_blm;
        logic                 cur_vsp;
        logic [BYTE_W-1:0]    b;
        logic [BYTE_W-1:0]    up;
        logic [BYTE_W-1:0]    ob;
        logic [ROLE_W-1:0]    role;
        logic                 tend;
        logic [STATUS_W-1:0]  status;
        logic [SKIP_W-1:0]    dec;

        // Start of request clears state before this byte
        if (in_start_reg)
        begin
            cur_phase   = PH_METHOD;
            cur_skip    = '0;
            cur_method  = M_UNKNOWN;
            cur_version = V_UNKNOWN;
            cur_blm     = BLM_IDLE;
            cur_vsp     = 1'b0;
        end
        else
        begin
            cur_phase   = phase_reg;
            cur_skip    = skip_reg;
            cur_method  = method_reg;
            cur_version = version_reg;
            cur_blm     = blm_reg;
            cur_vsp     = vsp_reg;
        end

        b      = in_byte_reg;
        up     = (b >= CH_LOWER_A && b <= CH_LOWER_Z) ? (b - CASE_BIT) : b;
        ob     = b;
        role   = ROLE_SKIP;
        tend   = 1'b0;
        status = ST_PARSING;
        dec    = cur_skip - SKIP_W'(1);

        phase_next   = cur_phase;
        skip_next    = cur_skip;
        method_next  = cur_method;
        version_next = cur_version;
        blm_next     = cur_blm;
        vsp_next     = cur_vsp;

        unique case (cur_phase)
            PH_METHOD:
            begin
                phase_next = PH_MSKIP;
                unique case (up)
                    CH_G:
                    begin
                        method_next = M_GET;
                        skip_next   = SKIP_GET;
                    end
                    CH_O:
                    begin
                        method_next = M_OPTIONS;
                        skip_next   = SKIP_OPTIONS;
                    end
                    CH_H:
                    begin
                        method_next = M_HEAD;
                        skip_next   = SKIP_HEAD;
                    end
                    CH_D:
                    begin
                        method_next = M_DELETE;
                        skip_next   = SKIP_DELETE;
                    end
                    CH_C:
                    begin
                        method_next = M_CONNECT;
                        skip_next   = SKIP_CONNECT;
                    end
                    CH_T:
                    begin
                        method_next = M_TRACE;
                        skip_next   = SKIP_TRACE;
                    end
                    CH_P:    phase_next = PH_PSECOND;
                    default: phase_next = PH_URL;
                endcase
            end
            PH_PSECOND:
            begin
                phase_next = PH_MSKIP;
                if (up == CH_O)
                begin
                    method_next = M_POST;
                    skip_next   = SKIP_POST;
                end
                else if (up == CH_U)
                begin
                    method_next = M_PUT;
                    skip_next   = SKIP_PUT;
                end
                else
                begin
                    method_next = M_PATCH;
                    skip_next   = SKIP_PATCH;
                end
            end
            PH_MSKIP:
            begin
                skip_next = dec;
                if (dec == '0)
                    phase_next = PH_URL;
            end
            PH_URL:
            begin
                if (b == CH_SPACE)
                begin
                    tend       = 1'b1;
                    skip_next  = SKIP_PROTO;
                    phase_next = PH_PROTOSKIP;
                end
                else
                    role = ROLE_URL;
            end
            PH_PROTOSKIP:
            begin
                skip_next = dec;
                if (dec == '0)
                    phase_next = PH_VERSION;
            end
            PH_VERSION:
            begin
                if (b == CH_ONE)
                    version_next = V_HTTP11;
                else if (b == CH_ZERO)
                    version_next = V_HTTP10;
                skip_next  = SKIP_EOL;
                phase_next = PH_EOLSKIP;
            end
            PH_EOLSKIP:
            begin
                skip_next = dec;
                if (dec == '0)
                begin
                    phase_next = PH_NAME;
                    blm_next   = BLM_LINE_START;
                end
            end
            PH_NAME:
            begin
                if (cur_blm == BLM_LINE_START && b == CH_CR)
                    blm_next = BLM_SAW_CR;
                else if (cur_blm == BLM_SAW_CR && b == CH_LF)
                begin
                    // Empty line: headers end
                    blm_next = BLM_IDLE;
                    if (in_end_reg)
                    begin
                        status     = ST_COMPLETE;
                        phase_next = PH_DONE;
                    end
                    else if (cur_method == M_GET || cur_method == M_HEAD)
                    begin
                        status     = ST_PIPELINED;
                        skip_next  = '0;
                        phase_next = PH_METHOD;
                    end
                    else
                        phase_next = PH_BODY;
                end
                else
                begin
                    blm_next = BLM_IDLE;
                    if (b == CH_COLON)
                    begin
                        tend       = 1'b1;
                        vsp_next   = 1'b1;
                        phase_next = PH_VALUE;
                    end
                    else
                    begin
                        role = ROLE_NAME;
                        if (b >= CH_UPPER_A)
                            ob = b | CASE_BIT;
                    end
                end
            end
            PH_VALUE:
            begin
                vsp_next = 1'b0;
                if (!(cur_vsp && b == CH_SPACE))
                begin
                    if (b == CH_CR)
                    begin
                        tend       = 1'b1;
                        phase_next = PH_VALUELF;
                    end
                    else
                        role = ROLE_VALUE;
                end
            end
            PH_VALUELF:
            begin
                phase_next = PH_NAME;
                blm_next   = BLM_LINE_START;
            end
            PH_BODY:
            begin
                role = ROLE_BODY;
                if (in_end_reg)
                begin
                    status     = ST_COMPLETE;
                    phase_next = PH_DONE;
                end
            end
            default:
            begin
                phase_next = PH_DONE;
                status     = ST_COMPLETE;
            end
        endcase

        // Flag a buffer end that leaves the request open
        if (status == ST_PARSING && in_end_reg)
            status = ST_NEED_MORE;

        res_next.out_byte     = ob;
        res_next.byte_role    = role;
        res_next.token_end    = tend;
        res_next.method_code  = method_next;
        res_next.version_code = version_next;
        res_next.parse_status = status;
    end

    // Control and parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_METHOD;
            skip_reg      <= '0;
            method_reg    <= M_UNKNOWN;
            version_reg   <= V_UNKNOWN;
            blm_reg       <= BLM_IDLE;
            vsp_reg       <= 1'b0;
        end
        else
        begin
            if (rx.ready)
                in_valid_reg <= rx.valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (step)
            begin
                phase_reg   <= phase_next;
                skip_reg    <= skip_next;
                method_reg  <= method_next;
                version_reg <= version_next;
                blm_reg     <= blm_next;
                vsp_reg     <= vsp_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            in_byte_reg  <= rx.data_byte;
            in_end_reg   <= rx.buffer_end;
            in_start_reg <= rx.start_request;
        end
        if (step)
            res_reg <= res_next;
    end

    // Drive the result channel
    assign tx.valid        = out_valid_reg;
    assign tx.out_byte     = res_reg.out_byte;
    assign tx.byte_role    = res_reg.byte_role;
    assign tx.token_end    = res_reg.token_end;
    assign tx.method_code  = res_reg.method_code;
    assign tx.version_code = res_reg.version_code;
    assign tx.parse_status = res_reg.parse_status;

endmodule

// ----- tb/http_request_header_tokenizer_top_test.sv -----
// ----------------------------------------------------------------------------
// http_request_header_tokenizer_top_test
// Drives request byte streams into the header tokenizer and checks every
// tagged byte field by field against an in-bench model of the parser. A
// short directed table covers each method letter, extreme byte values and
// the blank-line and completion cases. Random well-formed requests follow,
// mixed with truncated requests and noise, under random stalls on both
// channels.
// ----------------------------------------------------------------------------
module http_request_header_tokenizer_top_test;
    import hrt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1870;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_AFTER   = 600;
    localparam int HOLD_CYCLES  = 120;
    localparam int REPORT_MAX   = 10;
    localparam int DIRECTED_ROWS = 28;

    typedef struct packed {
        logic [BYTE_W-1:0] b;
        logic              be;
        logic              sr;
    } rx_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] b;
        logic              be;
        logic              sr;
        logic              typed;
        hrt_result_t       want;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n;

    hrt_in_if  rx_if ();
    hrt_out_if tx_if ();

    http_request_header_tokenizer_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .tx    (tx_if)
    );

    always #1 clk = ~clk;

    // Parser model state
    hrt_phase_t           cur_phase;
    logic [SKIP_W-1:0]    skip_left;
    logic [METHOD_W-1:0]  held_method;
    logic [VERSION_W-1:0] held_version;
    logic [BLM_W-1:0]     crlf_track;
    logic                 space_skip_armed;

    hrt_result_t expected_tags[$];
    rx_item_t    request_bytes[$];

    int cycle_count = 0;
    int fail_count = 0;
    int results_checked = 0;
    int requests_built = 0;
    int n_complete = 0;
    int n_pipelined = 0;
    int n_need_more = 0;
    logic [15:0] methods_seen = '0;

    // Method letters, an unknown first byte, the url extremes, a bad version
    // digit, then a blank line that completes the request and one more byte.
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{"G", 1'b0, 1'b1, 1'b1, '{"G", ROLE_SKIP, 1'b0, M_GET, V_UNKNOWN, ST_PARSING}},
        '{"o", 1'b0, 1'b1, 1'b1,
          '{"o", ROLE_SKIP, 1'b0, M_OPTIONS, V_UNKNOWN, ST_PARSING}},
        '{"P", 1'b0, 1'b1, 1'b0, '0},
        '{"O", 1'b0, 1'b0, 1'b0, '0},
        '{"p", 1'b0, 1'b1, 1'b0, '0},
        '{"u", 1'b0, 1'b0, 1'b0, '0},
        '{"P", 1'b0, 1'b1, 1'b0, '0},
        '{"A", 1'b0, 1'b0, 1'b0, '0},
        '{"h", 1'b0, 1'b1, 1'b1, '{"h", ROLE_SKIP, 1'b0, M_HEAD, V_UNKNOWN, ST_PARSING}},
        '{"D", 1'b0, 1'b1, 1'b1,
          '{"D", ROLE_SKIP, 1'b0, M_DELETE, V_UNKNOWN, ST_PARSING}},
        '{"c", 1'b0, 1'b1, 1'b1,
          '{"c", ROLE_SKIP, 1'b0, M_CONNECT, V_UNKNOWN, ST_PARSING}},
        '{"t", 1'b1, 1'b1, 1'b1,
          '{"t", ROLE_SKIP, 1'b0, M_TRACE, V_UNKNOWN, ST_NEED_MORE}},
        '{8'hFF, 1'b0, 1'b1, 1'b1,
          '{8'hFF, ROLE_SKIP, 1'b0, M_UNKNOWN, V_UNKNOWN, ST_PARSING}},
        '{8'h00, 1'b0, 1'b0, 1'b1,
          '{8'h00, ROLE_URL, 1'b0, M_UNKNOWN, V_UNKNOWN, ST_PARSING}},
        '{" ", 1'b0, 1'b0, 1'b1,
          '{" ", ROLE_SKIP, 1'b1, M_UNKNOWN, V_UNKNOWN, ST_PARSING}},
        '{"H", 1'b0, 1'b0, 1'b0, '0},
        '{"T", 1'b0, 1'b0, 1'b0, '0},
        '{"T", 1'b0, 1'b0, 1'b0, '0},
        '{"P", 1'b0, 1'b0, 1'b0, '0},
        '{"/", 1'b0, 1'b0, 1'b0, '0},
        '{"1", 1'b0, 1'b0, 1'b0, '0},
        '{".", 1'b0, 1'b0, 1'b0, '0},
        '{"9", 1'b0, 1'b0, 1'b1,
          '{"9", ROLE_SKIP, 1'b0, M_UNKNOWN, V_UNKNOWN, ST_PARSING}},
        '{CH_CR, 1'b0, 1'b0, 1'b0, '0},
        '{CH_LF, 1'b0, 1'b0, 1'b0, '0},
        '{CH_CR, 1'b0, 1'b0, 1'b0, '0},
        '{CH_LF, 1'b1, 1'b0, 1'b1,
          '{CH_LF, ROLE_SKIP, 1'b0, M_UNKNOWN, V_UNKNOWN, ST_COMPLETE}},
        '{8'h80, 1'b0, 1'b0, 1'b1,
          '{8'h80, ROLE_SKIP, 1'b0, M_UNKNOWN, V_UNKNOWN, ST_COMPLETE}}
    };

    // ------------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------------
    function automatic void clear_tokenizer();
        cur_phase        = PH_METHOD;
        skip_left        = '0;
        held_method      = M_UNKNOWN;
        held_version     = V_UNKNOWN;
        crlf_track       = BLM_IDLE;
        space_skip_armed = 1'b0;
    endfunction

    function automatic void enter_method(logic [METHOD_W-1:0] code,
                                         logic [SKIP_W-1:0] n);
        held_method = code;
        skip_left   = n;
        cur_phase   = (n != 0) ? PH_MSKIP : PH_URL;
    endfunction

    function automatic hrt_result_t tokenize_byte(logic [BYTE_W-1:0] b, logic last,
                                                  logic fresh);
        hrt_result_t r;
        logic [BYTE_W-1:0] up;
        if (fresh)
            clear_tokenizer();
        up = (b >= CH_LOWER_A && b <= CH_LOWER_Z) ? b - CASE_BIT : b;
        r.out_byte     = b;
        r.byte_role    = ROLE_SKIP;
        r.token_end    = 1'b0;
        r.parse_status = ST_PARSING;
        case (cur_phase)
            PH_METHOD:
            begin
                case (up)
                    CH_G: enter_method(M_GET, SKIP_GET);
                    CH_O: enter_method(M_OPTIONS, SKIP_OPTIONS);
                    CH_P: cur_phase = PH_PSECOND;
                    CH_H: enter_method(M_HEAD, SKIP_HEAD);
                    CH_D: enter_method(M_DELETE, SKIP_DELETE);
                    CH_C: enter_method(M_CONNECT, SKIP_CONNECT);
                    CH_T: enter_method(M_TRACE, SKIP_TRACE);
                    default: cur_phase = PH_URL;
                endcase
            end
            PH_PSECOND:
            begin
                if (up == CH_O)
                    enter_method(M_POST, SKIP_POST);
                else if (up == CH_U)
                    enter_method(M_PUT, SKIP_PUT);
                else
                    enter_method(M_PATCH, SKIP_PATCH);
            end
            PH_MSKIP:
            begin
                skip_left = skip_left - 1'b1;
                if (skip_left == 0)
                    cur_phase = PH_URL;
            end
            PH_URL:
            begin
                if (b == CH_SPACE)
                begin
                    r.token_end = 1'b1;
                    skip_left   = SKIP_PROTO;
                    cur_phase   = PH_PROTOSKIP;
                end
                else
                begin
                    r.byte_role = ROLE_URL;
                end
            end
            PH_PROTOSKIP:
            begin
                skip_left = skip_left - 1'b1;
                if (skip_left == 0)
                    cur_phase = PH_VERSION;
            end
            PH_VERSION:
            begin
                if (b == CH_ONE)
                    held_version = V_HTTP11;
                else if (b == CH_ZERO)
                    held_version = V_HTTP10;
                skip_left = SKIP_EOL;
                cur_phase = PH_EOLSKIP;
            end
            PH_EOLSKIP:
            begin
                skip_left = skip_left - 1'b1;
                if (skip_left == 0)
                begin
                    cur_phase  = PH_NAME;
                    crlf_track = BLM_LINE_START;
                end
            end
            PH_NAME:
            begin
                if (crlf_track == BLM_LINE_START && b == CH_CR)
                begin
                    crlf_track = BLM_SAW_CR;
                end
                else if (crlf_track == BLM_SAW_CR && b == CH_LF)
                begin
                    // Blank line: end of headers
                    crlf_track = BLM_IDLE;
                    if (held_method == M_GET || held_method == M_HEAD)
                    begin
                        if (last)
                        begin
                            r.parse_status = ST_COMPLETE;
                            cur_phase      = PH_DONE;
                        end
                        else
                        begin
                            r.parse_status = ST_PIPELINED;
                            skip_left      = '0;
                            cur_phase      = PH_METHOD;
                        end
                    end
                    else if (last)
                    begin
                        r.parse_status = ST_COMPLETE;
                        cur_phase      = PH_DONE;
                    end
                    else
                    begin
                        cur_phase = PH_BODY;
                    end
                end
                else
                begin
                    crlf_track = BLM_IDLE;
                    if (b == CH_COLON)
                    begin
                        r.token_end      = 1'b1;
                        space_skip_armed = 1'b1;
                        cur_phase        = PH_VALUE;
                    end
                    else
                    begin
                        r.byte_role = ROLE_NAME;
                        if (b >= CH_UPPER_A)
                            r.out_byte = b | CASE_BIT;
                    end
                end
            end
            PH_VALUE:
            begin
                if (space_skip_armed && b == CH_SPACE)
                begin
                    space_skip_armed = 1'b0;
                end
                else
                begin
                    space_skip_armed = 1'b0;
                    if (b == CH_CR)
                    begin
                        r.token_end = 1'b1;
                        cur_phase   = PH_VALUELF;
                    end
                    else
                    begin
                        r.byte_role = ROLE_VALUE;
                    end
                end
            end
            PH_VALUELF:
            begin
                cur_phase  = PH_NAME;
                crlf_track = BLM_LINE_START;
            end
            PH_BODY:
            begin
                r.byte_role = ROLE_BODY;
                if (last)
                begin
                    r.parse_status = ST_COMPLETE;
                    cur_phase      = PH_DONE;
                end
            end
            default:
            begin
                cur_phase      = PH_DONE;
                r.parse_status = ST_COMPLETE;
            end
        endcase
        if (r.parse_status == ST_PARSING && last)
            r.parse_status = ST_NEED_MORE;
        r.method_code  = held_method;
        r.version_code = held_version;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request generation
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [BYTE_W-1:0] mixed_case(logic [BYTE_W-1:0] c);
        if (c >= CH_UPPER_A && c <= "Z" && $urandom_range(0, 1) == 1)
            return c | CASE_BIT;
        return c;
    endfunction

    function automatic string method_word(int code);
        string pool;
        int k;
        pool = "ABEFIJKLMNQRSVWXYZ/0";
        case (code)
            M_GET:     return "GET ";
            M_OPTIONS: return "OPTIONS ";
            M_POST:    return "POST ";
            M_PUT:     return "PUT ";
            M_PATCH:   return "PATCH ";
            M_HEAD:    return "HEAD ";
            M_DELETE:  return "DELETE ";
            M_CONNECT: return "CONNECT ";
            M_TRACE:   return "TRACE ";
            default:
            begin
                k = $urandom_range(0, pool.len() - 1);
                return pool.substr(k, k);
            end
        endcase
    endfunction

    function automatic void push_byte(logic [BYTE_W-1:0] b);
        rx_item_t it;
        it.b  = b;
        it.be = ($urandom_range(0, 39) == 0);
        it.sr = 1'b0;
        request_bytes.push_back(it);
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endfunction

    function automatic logic [BYTE_W-1:0] printable_or_high(logic [BYTE_W-1:0] lo);
        if ($urandom_range(0, 7) == 0)
            return BYTE_W'($urandom_range(8'h80, 8'hFF));
        return BYTE_W'($urandom_range(lo, 8'h7E));
    endfunction

    // Build one request with random content; sometimes cut it short
    function automatic void build_request();
        int code;
        int n;
        string word;
        logic [BYTE_W-1:0] c;
        rx_item_t it;
        code = $urandom_range(0, 9);
        word = method_word(code);
        for (int i = 0; i < word.len(); i++)
            push_byte(mixed_case(word[i]));
        n = $urandom_range(0, 10);
        repeat (n)
        begin
            c = ($urandom_range(0, 3) != 0) ? BYTE_W'($urandom_range(8'h21, 8'h7E))
                                            : BYTE_W'($urandom_range(0, 255));
            if (c == CH_SPACE)
                c = "/";
            push_byte(c);
        end
        push_text(" HTTP/1.");
        n = $urandom_range(0, 99);
        push_byte((n < 45) ? CH_ONE : (n < 90) ? CH_ZERO : BYTE_W'($urandom_range(0, 255)));
        push_text("\r\n");
        repeat ($urandom_range(0, 3))
        begin
            // lone CR at a line start, then an ordinary name
            if ($urandom_range(0, 9) == 0)
                push_byte(CH_CR);
            repeat ($urandom_range(1, 8))
            begin
                c = printable_or_high(8'h21);
                if (c == CH_COLON)
                    c = "-";
                push_byte(mixed_case(c));
            end
            push_byte(CH_COLON);
            if ($urandom_range(0, 3) != 0)
                push_byte(CH_SPACE);
            repeat ($urandom_range(0, 10))
            begin
                c = ($urandom_range(0, 9) == 0) ? BYTE_W'($urandom_range(0, 255))
                                                : printable_or_high(8'h20);
                if (c == CH_CR)
                    c = CH_LF;
                push_byte(c);
            end
            push_text("\r\n");
        end
        push_text("\r\n");
        if (code != M_GET && code != M_HEAD)
        begin
            repeat ($urandom_range(0, 6))
                push_byte(BYTE_W'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(1, request_bytes.size() - 1);
            while (request_bytes.size() > n)
                void'(request_bytes.pop_back());
        end
        it = request_bytes.pop_back();
        it.be = ($urandom_range(0, 99) < 60);
        request_bytes.push_back(it);
        it = request_bytes.pop_front();
        it.sr = ($urandom_range(0, 5) != 0);
        request_bytes.push_front(it);
        requests_built++;
    endfunction

    function automatic void build_noise();
        rx_item_t it;
        repeat ($urandom_range(1, 8))
        begin
            it.b  = BYTE_W'($urandom_range(0, 255));
            it.be = ($urandom_range(0, 3) == 0);
            it.sr = ($urandom_range(0, 4) == 0);
            request_bytes.push_back(it);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    task automatic send_byte(rx_item_t it, logic typed, hrt_result_t want, bit quiet);
        hrt_result_t predicted;
        int gap;
        rx_if.valid         <= 1'b1;
        rx_if.data_byte     <= it.b;
        rx_if.buffer_end    <= it.be;
        rx_if.start_request <= it.sr;
        @(posedge clk);
        while (!rx_if.ready)
            @(posedge clk);
        // predict at the transfer so the model sees bytes in order
        predicted = tokenize_byte(it.b, it.be, it.sr);
        expected_tags.push_back(typed ? want : predicted);
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        rx_item_t it;
        int random_sent;
        bit paused;
        bit quiet;
        random_sent = 0;
        paused = 1'b0;
        rst_n = 1'b0;
        rx_if.valid = 1'b0;
        rx_if.data_byte = '0;
        rx_if.buffer_end = 1'b0;
        rx_if.start_request = 1'b0;
        clear_tokenizer();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            it.b  = directed_rows[i].b;
            it.be = directed_rows[i].be;
            it.sr = directed_rows[i].sr;
            send_byte(it, directed_rows[i].typed, directed_rows[i].want, 1'b0);
        end

        // Random requests, truncated requests and noise
        while (random_sent < RANDOM_ITEMS)
        begin
            request_bytes.delete();
            if ($urandom_range(0, 9) == 0)
                build_noise();
            else
                build_request();
            quiet = ($urandom_range(0, 3) == 0);
            while (request_bytes.size() > 0)
            begin
                it = request_bytes.pop_front();
                send_byte(it, 1'b0, '0, quiet);
                random_sent++;
                // hold the sender once until the pipe runs dry
                if (!paused && random_sent >= RANDOM_ITEMS / 2)
                begin
                    paused = 1'b1;
                    rx_if.valid <= 1'b0;
                    while (expected_tags.size() != 0)
                        @(posedge clk);
                end
            end
        end
        rx_if.valid <= 1'b0;

        while (expected_tags.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d tagged bytes from %0d random requests plus directed rows",
                 results_checked, requests_built);
        $display("Status seen: %0d complete, %0d pipelined, %0d need-more; methods %b",
                 n_complete, n_pipelined, n_need_more, methods_seen);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random stalls, one long hold-off
    // ------------------------------------------------------------------------
    initial
    begin
        int stall_left;
        int stall_pct;
        bit held;
        stall_left = 0;
        stall_pct = 20;
        held = 1'b0;
        tx_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (cycle_count % 256 == 0)
                stall_pct = ($urandom_range(0, 3) == 0) ? 0 : 20;
            if (!held && results_checked >= HOLD_AFTER)
            begin
                held = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                tx_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                tx_if.ready <= 1'b1;
                if ($urandom_range(0, 99) < stall_pct)
                    stall_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_failure(string what, hrt_result_t want, hrt_result_t got);
        fail_count++;
        if (fail_count <= REPORT_MAX)
        begin
            $display("%s at cycle %0d", what, cycle_count);
            $display("  want byte %02h role %0d end %0b method %0d version %0d status %0d",
                     want.out_byte, want.byte_role, want.token_end, want.method_code,
                     want.version_code, want.parse_status);
            $display("  got  byte %02h role %0d end %0b method %0d version %0d status %0d",
                     got.out_byte, got.byte_role, got.token_end, got.method_code,
                     got.version_code, got.parse_status);
        end
    endtask

    always @(posedge clk)
    begin
        hrt_result_t got;
        hrt_result_t want;
        if (rst_n && tx_if.valid && tx_if.ready)
        begin
            got.out_byte     = tx_if.out_byte;
            got.byte_role    = tx_if.byte_role;
            got.token_end    = tx_if.token_end;
            got.method_code  = tx_if.method_code;
            got.version_code = tx_if.version_code;
            got.parse_status = tx_if.parse_status;
            if (expected_tags.size() == 0)
            begin
                report_failure("Tagged byte with nothing expected", got, got);
            end
            else
            begin
                want = expected_tags.pop_front();
                if (got !== want)
                    report_failure("Tagged byte mismatch", want, got);
                results_checked++;
                if (want.parse_status == ST_COMPLETE)
                    n_complete++;
                if (want.parse_status == ST_PIPELINED)
                    n_pipelined++;
                if (want.parse_status == ST_NEED_MORE)
                    n_need_more++;
                methods_seen[want.method_code] = 1'b1;
            end
        end
    end

    // Count cycles; stop a hung run
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d tagged bytes outstanding",
                 cycle_count, expected_tags.size());
        $display("FAILURE");
        $finish;
    end

endmodule
